[hdl/drt_pkg.sv]
// Shared types and constants of the dirty rectangle tracker.
`timescale 1ns / 1ps
package drt_pkg;

    localparam int OUT_BITS = 12;

    // input beat kinds, carried on s_tuser
    typedef enum logic [1:0] {
        KIND_INV   = 2'd0,
        KIND_SPLIT = 2'd1,
        KIND_WHOLE = 2'd2,
        KIND_FLUSH = 2'd3
    } kind_e;

    // result beat kinds, carried on m_tuser
    typedef enum logic [1:0] {
        ITEM_RECT = 2'd0,
        ITEM_FULL = 2'd1,
        ITEM_END  = 2'd2
    } item_e;

    // configuration register indexes
    localparam logic [1:0] REG_SCREEN_W = 2'd0;
    localparam logic [1:0] REG_SCREEN_H = 2'd1;
    localparam logic [1:0] REG_VIEW_Y   = 2'd2;

    localparam logic [OUT_BITS-1:0] RST_SCREEN_W = 12'd640;
    localparam logic [OUT_BITS-1:0] RST_SCREEN_H = 12'd480;
    localparam logic [OUT_BITS-1:0] RST_VIEW_Y   = 12'd360;

    typedef struct packed {
        logic [OUT_BITS-1:0] screen_w;
        logic [OUT_BITS-1:0] screen_h;
        logic [OUT_BITS-1:0] view_y;
    } cfg_t;

    // one clipped operation for the back end
    typedef struct packed {
        kind_e               cmd;
        logic                empty;
        logic                scroll;
        logic [OUT_BITS-1:0] x;
        logic [OUT_BITS-1:0] y;
        logic [OUT_BITS-1:0] w;
        logic [OUT_BITS-1:0] h;
    } op_t;

endpackage

[hdl/drt_front.sv]
// Front end: takes input beats, cuts split rectangles and clips them to the screen.
`timescale 1ns / 1ps
module drt_front #(
    parameter int COORD_W = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  drt_pkg::cfg_t       cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [71:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                q_full,
    output logic                q_push,
    output drt_pkg::op_t        q_op
);
    import drt_pkg::*;

    localparam logic [OUT_BITS:0] ONE_SH = (OUT_BITS + 1)'(1) << COORD_W;
    localparam logic [OUT_BITS-1:0] CMASK = OUT_BITS'(ONE_SH - 1'b1);

    logic phase_reg, phase_next;
    kind_e kind;
    logic signed [17:0] l_s, t_s, r_s, b_s, v_s, sw_s, sh_s;
    logic signed [17:0] top_s, bot_s, lc, tc, rc, bc, w_s, h_s;
    logic straddle, need_two;

    always_comb begin
        kind  = kind_e'(s_tuser);
        l_s   = {{2{s_tdata[15]}}, s_tdata[15:0]};
        t_s   = {{2{s_tdata[31]}}, s_tdata[31:16]};
        r_s   = {{2{s_tdata[47]}}, s_tdata[47:32]};
        b_s   = {{2{s_tdata[63]}}, s_tdata[63:48]};
        v_s   = {6'b0, cfg.view_y};
        sw_s  = {6'b0, cfg.screen_w};
        sh_s  = {6'b0, cfg.screen_h};
        straddle = (t_s <= v_s) && (b_s > v_s);
        need_two = (kind == KIND_SPLIT) && straddle;
        // upper half first, then the lower half once the upper half has been pushed
        top_s = (need_two && phase_reg) ? v_s : t_s;
        bot_s = (need_two && !phase_reg) ? v_s : b_s;
        lc = (l_s < 18'sd0) ? 18'sd0 : l_s;
        tc = (top_s < 18'sd0) ? 18'sd0 : top_s;
        rc = (r_s > sw_s) ? sw_s : r_s;
        bc = (bot_s > sh_s) ? sh_s : bot_s;
        w_s = rc - lc;
        h_s = bc - tc;

        q_op.cmd    = kind;
        q_op.empty  = (w_s <= 18'sd0) || (h_s <= 18'sd0);
        q_op.scroll = s_tdata[64];
        q_op.x      = lc[OUT_BITS-1:0] & CMASK;
        q_op.y      = tc[OUT_BITS-1:0] & CMASK;
        q_op.w      = w_s[OUT_BITS-1:0] & CMASK;
        q_op.h      = h_s[OUT_BITS-1:0] & CMASK;

        q_push   = s_tvalid && !q_full;
        s_tready = !q_full && !(need_two && !phase_reg);
        phase_next = phase_reg;
        if (q_push && need_two) begin
            phase_next = !phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

[hdl/drt_queue.sv]
// Short operation queue between front and back end.
`timescale 1ns / 1ps
module drt_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  drt_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output drt_pkg::op_t  pop_op
);
    import drt_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    op_t            slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]    count_reg;
    logic           do_push, do_pop;

    assign full    = (count_reg == (PW + 1)'(DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_op  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[hdl/drt_back.sv]
// Back end: rectangle tables, overflow handling and flush streaming.
`timescale 1ns / 1ps
module drt_back #(
    parameter int MAX_REGIONS = 16,
    parameter int COORD_W     = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  drt_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  drt_pkg::op_t        q_op,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import drt_pkg::*;

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLAIN,
        ST_SPLIT
    } state_t;

    state_t state_reg;
    logic force_full_reg, scroll_reg;
    logic [CNT_W-1:0] plain_cnt_reg, split_cnt_reg, idx_reg;
    logic [3:0][COORD_W-1:0] plain_tab_reg [MAX_REGIONS];
    logic [3:0][COORD_W-1:0] split_tab_reg [MAX_REGIONS];

    logic m_valid_reg, m_last_reg;
    item_e m_type_reg;
    logic [OUT_BITS-1:0] m_x_reg, m_y_reg, m_w_reg, m_h_reg;

    logic slot_free, plain_full, split_full, plain_we, split_we;
    logic [3:0][COORD_W-1:0] rd;
    logic [OUT_BITS-1:0] rd_x, rd_y, rd_w, rd_h;
    logic [OUT_BITS:0] rd_bottom;
    logic [3:0][COORD_W-1:0] wr_entry;

    always_comb begin
        slot_free  = !m_valid_reg || m_tready;
        plain_full = (plain_cnt_reg >= CNT_W'(MAX_REGIONS));
        split_full = (split_cnt_reg >= CNT_W'(MAX_REGIONS));
        q_pop = q_valid && (state_reg == ST_IDLE)
                && ((q_op.cmd != KIND_FLUSH) || slot_free);
        plain_we = q_pop && (q_op.cmd == KIND_INV) && !force_full_reg
                   && !plain_full && !q_op.empty;
        split_we = q_pop && (q_op.cmd == KIND_SPLIT) && !split_full && !q_op.empty;
        wr_entry[0] = q_op.x[COORD_W-1:0];
        wr_entry[1] = q_op.y[COORD_W-1:0];
        wr_entry[2] = q_op.w[COORD_W-1:0];
        wr_entry[3] = q_op.h[COORD_W-1:0];
        rd = (state_reg == ST_PLAIN) ? plain_tab_reg[idx_reg[IDX_W-1:0]]
                                     : split_tab_reg[idx_reg[IDX_W-1:0]];
        rd_x = OUT_BITS'(rd[0]);
        rd_y = OUT_BITS'(rd[1]);
        rd_w = OUT_BITS'(rd[2]);
        rd_h = OUT_BITS'(rd[3]);
        rd_bottom = {1'b0, rd_y} + {1'b0, rd_h};
    end

    always_ff @(posedge aclk) begin
        if (plain_we) begin
            plain_tab_reg[plain_cnt_reg[IDX_W-1:0]] <= wr_entry;
        end
        if (split_we) begin
            split_tab_reg[split_cnt_reg[IDX_W-1:0]] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            force_full_reg <= 1'b1;
            plain_cnt_reg  <= '0;
            split_cnt_reg  <= '0;
            idx_reg        <= '0;
            scroll_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        case (q_op.cmd)
                            KIND_INV: begin
                                if (!force_full_reg) begin
                                    if (plain_full) begin
                                        plain_cnt_reg  <= '0;
                                        split_cnt_reg  <= '0;
                                        force_full_reg <= 1'b1;
                                    end else if (!q_op.empty) begin
                                        plain_cnt_reg <= plain_cnt_reg + 1'b1;
                                    end
                                end
                            end
                            KIND_SPLIT: begin
                                if (split_full) begin
                                    plain_cnt_reg  <= '0;
                                    split_cnt_reg  <= '0;
                                    force_full_reg <= 1'b1;
                                end else if (!q_op.empty) begin
                                    split_cnt_reg <= split_cnt_reg + 1'b1;
                                end
                            end
                            KIND_WHOLE: begin
                                plain_cnt_reg  <= '0;
                                split_cnt_reg  <= '0;
                                force_full_reg <= 1'b1;
                            end
                            default: begin
                                scroll_reg <= q_op.scroll;
                                idx_reg    <= '0;
                                if (force_full_reg) begin
                                    m_valid_reg    <= 1'b1;
                                    m_type_reg     <= ITEM_FULL;
                                    m_x_reg        <= '0;
                                    m_y_reg        <= '0;
                                    m_w_reg        <= cfg.screen_w;
                                    m_h_reg        <= cfg.screen_h;
                                    m_last_reg     <= 1'b1;
                                    force_full_reg <= 1'b0;
                                    plain_cnt_reg  <= '0;
                                    split_cnt_reg  <= '0;
                                end else begin
                                    state_reg <= ST_PLAIN;
                                end
                            end
                        endcase
                    end
                end
                ST_PLAIN: begin
                    if (slot_free) begin
                        if (idx_reg < plain_cnt_reg) begin
                            m_valid_reg <= 1'b1;
                            m_type_reg  <= ITEM_RECT;
                            m_x_reg     <= rd_x;
                            m_y_reg     <= rd_y;
                            m_w_reg     <= rd_w;
                            m_h_reg     <= rd_h;
                            m_last_reg  <= 1'b0;
                            idx_reg     <= idx_reg + 1'b1;
                        end else begin
                            idx_reg   <= '0;
                            state_reg <= ST_SPLIT;
                        end
                    end
                end
                ST_SPLIT: begin
                    if (slot_free) begin
                        if (idx_reg < split_cnt_reg) begin
                            // while scrolling, rectangles wholly above the viewport edge go
                            if (!(scroll_reg && (rd_bottom <= {1'b0, cfg.view_y}))) begin
                                m_valid_reg <= 1'b1;
                                m_type_reg  <= ITEM_RECT;
                                m_x_reg     <= rd_x;
                                m_y_reg     <= rd_y;
                                m_w_reg     <= rd_w;
                                m_h_reg     <= rd_h;
                                m_last_reg  <= 1'b0;
                            end
                            idx_reg <= idx_reg + 1'b1;
                        end else begin
                            m_valid_reg    <= 1'b1;
                            m_type_reg     <= ITEM_END;
                            m_x_reg        <= '0;
                            m_y_reg        <= '0;
                            m_w_reg        <= '0;
                            m_h_reg        <= '0;
                            m_last_reg     <= 1'b1;
                            force_full_reg <= 1'b0;
                            plain_cnt_reg  <= '0;
                            split_cnt_reg  <= '0;
                            state_reg      <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_h_reg, m_w_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_type_reg;
    assign m_tlast  = m_last_reg;

endmodule

[hdl/dirty_rectangle_tracker.sv]
// An invalidation beat is taken by the front end (a split rectangle that straddles the
// viewport edge as an upper and a lower half) and lands in the tables via the op queue.
// Throughput: one invalidation per cycle while the op queue has room and the back end is idle.
// Once out of the queue, a flush streams the plain list, split list and end marker, or one full item,
// one table read per cycle while not stalled. Reset is synchronous, active low: full refresh pending,
// both lists empty, registers at 640 x 480 with the viewport edge at row 360; no clearing pass.
`timescale 1ns / 1ps
module dirty_rectangle_tracker #(
    parameter int MAX_REGIONS = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_data,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // rect_left, rect_top, rect_right, rect_bottom, scrolling
    input  logic [1:0]  s_tuser,  // kind
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // out_x, out_y, out_w, out_h
    output logic [1:0]  m_tuser,  // item_type
    output logic        m_tlast   // last
);
    import drt_pkg::*;

    localparam int COORD_W = (COORD_BITS < OUT_BITS) ? COORD_BITS : OUT_BITS;
    localparam logic [OUT_BITS:0] ONE_SH = (OUT_BITS + 1)'(1) << COORD_W;
    localparam logic [OUT_BITS-1:0] CMASK = OUT_BITS'(ONE_SH - 1'b1);

    cfg_t cfg_reg;
    logic q_full, q_push, q_valid, q_pop;
    op_t  push_op, pop_op;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_w <= RST_SCREEN_W & CMASK;
            cfg_reg.screen_h <= RST_SCREEN_H & CMASK;
            cfg_reg.view_y   <= RST_VIEW_Y & CMASK;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_SCREEN_W: cfg_reg.screen_w <= cfg_data & CMASK;
                REG_SCREEN_H: cfg_reg.screen_h <= cfg_data & CMASK;
                REG_VIEW_Y:   cfg_reg.view_y   <= cfg_data & CMASK;
                default: ;
            endcase
        end
    end

    drt_front #(
        .COORD_W (COORD_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    drt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .pop_op  (pop_op)
    );

    drt_back #(
        .MAX_REGIONS (MAX_REGIONS),
        .COORD_W     (COORD_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_op     (pop_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/sv/dirty_rectangle_tracker_tb.sv]
// Testbench for the dirty rectangle tracker: directed table, random frames, self-checking.
`timescale 1ns / 1ps
module dirty_rectangle_tracker_tb;
    import drt_pkg::*;

    localparam int MAX_RECTS   = 16;
    localparam int SETTLE      = 10;    // op queue drain before a register write
    localparam int QUIET_LIMIT = 3000;  // cycles with no beat on any channel
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct packed {
        item_e       kind;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
        logic        last;
    } refresh_item_t;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
    } rect_t;

    typedef struct packed {
        kind_e         k;
        logic [15:0]   l;
        logic [15:0]   t;
        logic [15:0]   r;
        logic [15:0]   b;
        logic          scroll;
        logic          typed;
        refresh_item_t res;
    } step_t;

    localparam refresh_item_t FULL_640 = '{ITEM_FULL, 12'd0, 12'd0, 12'd640, 12'd480, 1'b1};
    localparam refresh_item_t END_MARK = '{ITEM_END, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1};
    localparam refresh_item_t NO_RES   = '0;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr  = REG_SCREEN_W;
    logic [11:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;  // rect_left, rect_top, rect_right, rect_bottom, scrolling
    logic [1:0]  s_tuser   = KIND_INV;  // kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;         // out_x, out_y, out_w, out_h
    logic [1:0]  m_tuser;         // item_type
    logic        m_tlast;

    dirty_rectangle_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    // tracker image kept alongside the block
    int    scr_w = int'(RST_SCREEN_W);
    int    scr_h = int'(RST_SCREEN_H);
    int    view_y = int'(RST_VIEW_Y);
    bit    full_pending = 1'b1;
    rect_t plain_rects [MAX_RECTS];
    rect_t split_rects [MAX_RECTS];
    int    plain_n = 0;
    int    split_n = 0;

    refresh_item_t pending_items [$];
    int errors = 0;
    int tx_calm = 0;
    int rx_calm = 0;
    int quiet = 0;

    step_t directed_steps [20] = '{
        '{KIND_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, FULL_640},
        '{KIND_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, END_MARK},
        '{KIND_INV, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, NO_RES},
        '{KIND_INV, 16'd10, 16'd20, 16'd10, 16'd50, 1'b0, 1'b0, NO_RES},
        '{KIND_INV, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1, 1'b0, NO_RES},
        '{KIND_INV, 16'd100, 16'd50, 16'd200, 16'd80, 1'b0, 1'b0, NO_RES},
        '{KIND_SPLIT, 16'd0, 16'd300, 16'd50, 16'd400, 1'b0, 1'b0, NO_RES},
        '{KIND_SPLIT, 16'd5, 16'd360, 16'd15, 16'd370, 1'b0, 1'b0, NO_RES},
        '{KIND_SPLIT, 16'd5, 16'd10, 16'd15, 16'd360, 1'b1, 1'b0, NO_RES},
        '{KIND_SPLIT, 16'd700, 16'd0, 16'd800, 16'd10, 1'b0, 1'b0, NO_RES},
        '{KIND_SPLIT, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, NO_RES},
        '{KIND_FLUSH, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, NO_RES},
        '{KIND_INV, 16'd1, 16'd1, 16'd2, 16'd2, 1'b0, 1'b0, NO_RES},
        '{KIND_WHOLE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, NO_RES},
        '{KIND_INV, 16'd1, 16'd1, 16'd2, 16'd2, 1'b0, 1'b0, NO_RES},
        '{KIND_SPLIT, 16'd1, 16'd1, 16'd5, 16'd5, 1'b0, 1'b0, NO_RES},
        '{KIND_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, FULL_640},
        '{KIND_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, END_MARK},
        '{KIND_INV, 16'd0, 16'd0, 16'd640, 16'd480, 1'b0, 1'b0, NO_RES},
        '{KIND_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, NO_RES}
    };

    function automatic string describe(refresh_item_t it);
        return $sformatf("type %0d x %0d y %0d w %0d h %0d last %0d",
                         it.kind, it.x, it.y, it.w, it.h, it.last);
    endfunction

    function automatic int pick_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    endfunction

    // clip to the screen and append; a full list collapses everything to a full refresh
    function automatic void keep_rect(bit to_split, int l, int t, int r, int b);
        rect_t rc;
        if ((to_split ? split_n : plain_n) >= MAX_RECTS) begin
            plain_n = 0;
            split_n = 0;
            full_pending = 1'b1;
            return;
        end
        if (l < 0) l = 0;
        if (t < 0) t = 0;
        if (r > scr_w) r = scr_w;
        if (b > scr_h) b = scr_h;
        if (r - l <= 0 || b - t <= 0) return;
        rc = {12'(l), 12'(t), 12'(r - l), 12'(b - t)};
        if (to_split) begin
            split_rects[split_n] = rc;
            split_n++;
        end else begin
            plain_rects[plain_n] = rc;
            plain_n++;
        end
    endfunction

    function automatic void track_beat(kind_e k, logic [15:0] l16, logic [15:0] t16,
                                       logic [15:0] r16, logic [15:0] b16, logic scroll);
        int l = int'($signed(l16));
        int t = int'($signed(t16));
        int r = int'($signed(r16));
        int b = int'($signed(b16));
        case (k)
            KIND_INV: begin
                if (!full_pending) keep_rect(1'b0, l, t, r, b);
            end
            KIND_SPLIT: begin
                if (t <= view_y && b > view_y) begin
                    keep_rect(1'b1, l, t, r, view_y);
                    keep_rect(1'b1, l, view_y, r, b);
                end else begin
                    keep_rect(1'b1, l, t, r, b);
                end
            end
            KIND_WHOLE: begin
                plain_n = 0;
                split_n = 0;
                full_pending = 1'b1;
            end
            default: begin
                if (full_pending) begin
                    pending_items.push_back({ITEM_FULL, 12'd0, 12'd0, 12'(scr_w), 12'(scr_h),
                                             1'b1});
                end else begin
                    for (int i = 0; i < plain_n; i++)
                        pending_items.push_back({ITEM_RECT, plain_rects[i], 1'b0});
                    // scrolling: split rects wholly above the viewport edge are skipped
                    for (int i = 0; i < split_n; i++)
                        if (!(scroll && split_rects[i].y + split_rects[i].h <= view_y))
                            pending_items.push_back({ITEM_RECT, split_rects[i], 1'b0});
                    pending_items.push_back(END_MARK);
                end
                full_pending = 1'b0;
                plain_n = 0;
                split_n = 0;
            end
        endcase
    endfunction

    function automatic logic [63:0] pick_rect(bit straddle);
        int x0, y0, wd, ht;
        if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
        x0 = int'($urandom_range(0, scr_w + 40)) - 20;
        wd = int'($urandom_range(0, 260)) - 4;
        if (straddle) begin
            y0 = view_y - int'($urandom_range(0, 80));
            ht = view_y - y0 + int'($urandom_range(0, 80));
        end else begin
            y0 = int'($urandom_range(0, scr_h + 40)) - 20;
            ht = int'($urandom_range(0, 200)) - 4;
        end
        return {16'(y0 + ht), 16'(x0 + wd), 16'(y0), 16'(x0)};
    endfunction

    // called at a rising edge; returns at the edge the beat is taken
    task automatic send_beat(kind_e k, logic [15:0] l, logic [15:0] t, logic [15:0] r,
                             logic [15:0] b, logic scroll, bit typed, refresh_item_t res);
        int gap;
        int n0;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {7'd0, scroll, b, r, t, l};
        do @(posedge aclk); while (!s_tready);
        n0 = pending_items.size();
        track_beat(k, l, t, r, b, scroll);
        if (typed) begin
            while (pending_items.size() > n0) void'(pending_items.pop_back());
            pending_items.push_back(res);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        s_tvalid <= 1'b0;
        while (pending_items.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SCREEN_W: scr_w = int'(val);
            REG_SCREEN_H: scr_h = int'(val);
            REG_VIEW_Y:   view_y = int'(val);
            default: ;
        endcase
    endtask

    // result side back-pressure
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = pick_gap(rx_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : check_results
        refresh_item_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[11:0], m_tdata[23:12], m_tdata[35:24], m_tdata[47:36],
                   m_tlast};
            if (pending_items.size() == 0) begin
                errors++;
                if (errors <= 30) $display("%0t: unexpected result %s", $time, describe(got));
            end else begin
                want = pending_items.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 30)
                        $display("%0t: expected %s, got %s", $time, describe(want),
                                 describe(got));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int          ph_items, n, style, pick;
        kind_e       k;
        logic [63:0] rc;
        logic [11:0] cw, ch, cv;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i])
            send_beat(directed_steps[i].k, directed_steps[i].l, directed_steps[i].t,
                      directed_steps[i].r, directed_steps[i].b, directed_steps[i].scroll,
                      directed_steps[i].typed, directed_steps[i].res);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: begin cw = 12'd4095; ch = 12'd4095; cv = 12'd4095; end
                2: begin cw = 12'd1;    ch = 12'd1;    cv = 12'd0;    end
                3: begin cw = 12'd800;  ch = 12'd600;  cv = 12'd0;    end
                4: begin
                    cw = 12'($urandom_range(16, 1200));
                    ch = 12'($urandom_range(16, 1000));
                    cv = 12'($urandom_range(0, int'(ch) + 50));
                end
                default: begin cw = 12'd320; ch = 12'd240; cv = 12'd239; end
            endcase
            if (ph > 0) begin
                write_reg(REG_SCREEN_W, cw);
                write_reg(REG_SCREEN_H, ch);
                write_reg(REG_VIEW_Y, cv);
            end
            if (ph == 1) write_reg(REG_NONE, 12'hABC);
            ph_items = 0;
            while (ph_items < 12) begin
                // frame: floods can push a list past its limit, mixed frames cover the rest
                style = $urandom_range(0, 3);
                if (style == 0) n = $urandom_range(15, 19);
                else if (style == 1) n = $urandom_range(10, 18);
                else n = $urandom_range(0, 10);
                for (int j = 0; j < n; j++) begin
                    if (style == 0) begin
                        k = KIND_INV;
                    end else if (style == 1) begin
                        k = KIND_SPLIT;
                    end else begin
                        pick = $urandom_range(0, 19);
                        if (pick < 9) k = KIND_INV;
                        else if (pick < 18) k = KIND_SPLIT;
                        else if (pick < 19) k = KIND_WHOLE;
                        else k = KIND_FLUSH;
                    end
                    rc = pick_rect(k == KIND_SPLIT && $urandom_range(0, 1) == 1);
                    send_beat(k, rc[15:0], rc[31:16], rc[47:32], rc[63:48],
                              1'($urandom_range(0, 1)), 1'b0, NO_RES);
                end
                rc = {$urandom, $urandom};
                send_beat(KIND_FLUSH, rc[15:0], rc[31:16], rc[47:32], rc[63:48],
                          1'($urandom_range(0, 1)), 1'b0, NO_RES);
                ph_items += n + 1;
                if ((ph == 3 || $urandom_range(0, 5) == 0) && pending_items.size() != 0) begin
                    s_tvalid <= 1'b0;
                    while (pending_items.size() != 0) @(posedge aclk);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_items.size() != 0) @(posedge aclk);
        repeat (4 * SETTLE) @(posedge aclk);
        if (errors == 0 && pending_items.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
